// File: hw/rtl/cle_pkg.sv
// shared codes, widths and controller/datapath interface types for the cursor list engine
package cle_pkg;

  // element and field widths
  localparam int VAL_W = 32;
  localparam int ACT_W = 4;
  localparam int ST_W  = 2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_READ       = 4'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND     = 4'd1;
  localparam logic [ACT_W-1:0] ACT_PREPEND    = 4'd2;
  localparam logic [ACT_W-1:0] ACT_INS_BEFORE = 4'd3;
  localparam logic [ACT_W-1:0] ACT_INS_AFTER  = 4'd4;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DEL_BACK   = 4'd6;
  localparam logic [ACT_W-1:0] ACT_DEL_CURSOR = 4'd7;
  localparam logic [ACT_W-1:0] ACT_MV_FRONT   = 4'd8;
  localparam logic [ACT_W-1:0] ACT_MV_BACK    = 4'd9;
  localparam logic [ACT_W-1:0] ACT_MV_PREV    = 4'd10;
  localparam logic [ACT_W-1:0] ACT_MV_NEXT    = 4'd11;
  localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd12;

  // result status codes
  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] STAT_NOCUR = 2'd2;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic plan;
    logic shift_rd;
    logic wr_val;
    logic rd_front;
    logic rd_back;
    logic rd_cur;
    logic cap_front;
    logic cap_back;
    logic cap_cur;
    logic load_out;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic plan_moves;
    logic plan_ins;
    logic ins_q;
    logic sh_last;
  } stat_t;

endpackage

// File: hw/rtl/cle_ram.sv
// generic single write port, single read port ram with registered read data
module cle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/cle_ctrl.sv
// sequencing state machine for the cursor list engine
module cle_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  input  cle_pkg::stat_t stat,
  output cle_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLAN,
    S_SHIFT,
    S_DRAIN,
    S_WRVAL,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_OUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  // command decode from state
  always_comb begin
    cmd           = '0;
    cmd.load_item = (state == S_IDLE) && s_tvalid && s_tready;
    cmd.plan      = (state == S_PLAN);
    cmd.shift_rd  = (state == S_SHIFT);
    cmd.wr_val    = (state == S_WRVAL);
    cmd.rd_front  = (state == S_RD0);
    cmd.rd_back   = (state == S_RD1);
    cmd.cap_front = (state == S_RD1);
    cmd.rd_cur    = (state == S_RD2);
    cmd.cap_back  = (state == S_RD2);
    cmd.cap_cur   = (state == S_RD3);
    cmd.load_out  = (state == S_OUT) && out_free;
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !cmd.load_out) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            s_tready <= 1'b0;
            state    <= S_PLAN;
          end else begin
            s_tready <= 1'b1;
          end
        end
        S_PLAN: begin
          if (stat.plan_moves) begin
            state <= S_SHIFT;
          end else if (stat.plan_ins) begin
            state <= S_WRVAL;
          end else begin
            state <= S_RD0;
          end
        end
        S_SHIFT: begin
          if (stat.sh_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= stat.ins_q ? S_WRVAL : S_RD0;
        end
        S_WRVAL: begin
          state <= S_RD0;
        end
        S_RD0: begin
          state <= S_RD1;
        end
        S_RD1: begin
          state <= S_RD2;
        end
        S_RD2: begin
          state <= S_RD3;
        end
        S_RD3: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            s_tready <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/cle_dpath.sv
// list state, element ram, shift sequencing and result register
module cle_dpath #(
  parameter int CAPACITY = 64,
  localparam int CNT_W  = $clog2(CAPACITY + 1),
  localparam int POS_W  = $clog2(CAPACITY),
  localparam int OUT_W  = cle_pkg::ST_W + CNT_W + 1 + POS_W + 3 * cle_pkg::VAL_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cle_pkg::cmd_t             cmd,
  output cle_pkg::stat_t            stat,
  input  logic [cle_pkg::ACT_W-1:0] in_action,
  input  logic [cle_pkg::VAL_W-1:0] in_value,
  output logic [OUT_TW-1:0]         out_data
);

  // latched item
  logic [cle_pkg::ACT_W-1:0] act_q;
  logic [cle_pkg::VAL_W-1:0] val_q;

  // list state
  logic [CNT_W-1:0] len;
  logic [POS_W-1:0] cpos;
  logic             cdef;
  logic [cle_pkg::ST_W-1:0] st_q;

  // shift sequencer
  logic             ins_q;
  logic [POS_W-1:0] rd_ptr;
  logic [POS_W-1:0] sh_stop;
  logic [POS_W-1:0] val_addr;
  logic             wr_pend;
  logic [POS_W-1:0] wr_addr;

  // captured values
  logic [cle_pkg::VAL_W-1:0] front_q;
  logic [cle_pkg::VAL_W-1:0] back_q;
  logic [cle_pkg::VAL_W-1:0] curv_q;

  // plan signals
  logic             empty;
  logic             full;
  logic             is_cur_op;
  logic             is_pos_op;
  logic             is_ins_op;
  logic [CNT_W-1:0] cpos_w;
  logic [CNT_W-1:0] last;
  logic [cle_pkg::ST_W-1:0] p_st;
  logic [CNT_W-1:0] n_len;
  logic [POS_W-1:0] n_cpos;
  logic             n_cdef;
  logic             p_ins;
  logic             p_del;
  logic [CNT_W-1:0] p_pos;
  logic [CNT_W-1:0] p_start;
  logic [CNT_W-1:0] p_stop;
  logic             p_moves;

  // ram ports
  logic                      ram_we;
  logic [POS_W-1:0]          ram_waddr;
  logic [cle_pkg::VAL_W-1:0] ram_wdata;
  logic                      ram_re;
  logic [POS_W-1:0]          ram_raddr;
  logic [cle_pkg::VAL_W-1:0] ram_rdata;
  logic [POS_W-1:0]          back_addr;

  // error checks on the current state
  assign empty     = (len == '0);
  assign full      = (len == CNT_W'(CAPACITY));
  assign is_cur_op = (act_q == cle_pkg::ACT_INS_BEFORE) || (act_q == cle_pkg::ACT_INS_AFTER) ||
                     (act_q == cle_pkg::ACT_DEL_CURSOR);
  assign is_pos_op = (act_q >= cle_pkg::ACT_INS_BEFORE) && (act_q <= cle_pkg::ACT_MV_NEXT);
  assign is_ins_op = (act_q >= cle_pkg::ACT_APPEND) && (act_q <= cle_pkg::ACT_INS_AFTER);
  assign cpos_w    = CNT_W'(cpos);
  assign last      = len - CNT_W'(1);

  // next list state and cell to open or close
  always_comb begin
    p_st   = cle_pkg::STAT_OK;
    n_len  = len;
    n_cpos = cpos;
    n_cdef = cdef;
    p_ins  = 1'b0;
    p_del  = 1'b0;
    p_pos  = '0;
    if (is_pos_op && empty) begin
      p_st = cle_pkg::STAT_EMPTY;
    end else if (is_cur_op && !cdef) begin
      p_st = cle_pkg::STAT_NOCUR;
    end else if (is_ins_op && full) begin
      p_st = cle_pkg::STAT_FULL;
    end else begin
      case (act_q)
        cle_pkg::ACT_APPEND: begin
          p_ins = 1'b1;
          p_pos = len;
          n_len = len + CNT_W'(1);
        end
        cle_pkg::ACT_PREPEND: begin
          p_ins = 1'b1;
          n_len = len + CNT_W'(1);
          if (cdef) begin
            n_cpos = cpos + POS_W'(1);
          end
        end
        cle_pkg::ACT_INS_BEFORE: begin
          p_ins  = 1'b1;
          p_pos  = cpos_w;
          n_len  = len + CNT_W'(1);
          n_cpos = cpos + POS_W'(1);
        end
        cle_pkg::ACT_INS_AFTER: begin
          p_ins = 1'b1;
          p_pos = cpos_w + CNT_W'(1);
          n_len = len + CNT_W'(1);
        end
        cle_pkg::ACT_DEL_FRONT: begin
          p_del = 1'b1;
          n_len = last;
          if (cdef) begin
            if (cpos == '0) begin
              n_cdef = 1'b0;
            end else begin
              n_cpos = cpos - POS_W'(1);
            end
          end
        end
        cle_pkg::ACT_DEL_BACK: begin
          p_del = 1'b1;
          p_pos = last;
          n_len = last;
          if (cdef && (cpos_w == last)) begin
            n_cdef = 1'b0;
          end
        end
        cle_pkg::ACT_DEL_CURSOR: begin
          p_del  = 1'b1;
          p_pos  = cpos_w;
          n_len  = last;
          n_cdef = 1'b0;
        end
        cle_pkg::ACT_MV_FRONT: begin
          n_cdef = 1'b1;
          n_cpos = '0;
        end
        cle_pkg::ACT_MV_BACK: begin
          n_cdef = 1'b1;
          n_cpos = POS_W'(last);
        end
        cle_pkg::ACT_MV_PREV: begin
          if (cdef) begin
            if (cpos == '0) begin
              n_cdef = 1'b0;
            end else begin
              n_cpos = cpos - POS_W'(1);
            end
          end
        end
        cle_pkg::ACT_MV_NEXT: begin
          if (cdef) begin
            if ((cpos_w + CNT_W'(1)) >= len) begin
              n_cdef = 1'b0;
            end else begin
              n_cpos = cpos + POS_W'(1);
            end
          end
        end
        cle_pkg::ACT_CLEAR: begin
          n_len  = '0;
          n_cdef = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // an empty list or an undefined cursor parks the cursor at zero
    if (n_len == '0) begin
      n_cdef = 1'b0;
    end
    if (!n_cdef) begin
      n_cpos = '0;
    end
  end

  // range of cells to move: downward from the top on insert, upward on delete
  always_comb begin
    if (p_ins) begin
      p_start = last;
      p_stop  = p_pos;
      p_moves = (p_pos < len);
    end else begin
      p_start = p_pos + CNT_W'(1);
      p_stop  = last;
      p_moves = p_del && ((p_pos + CNT_W'(1)) < len);
    end
  end

  assign stat.plan_moves = p_moves;
  assign stat.plan_ins   = p_ins;
  assign stat.ins_q      = ins_q;
  assign stat.sh_last    = (rd_ptr == sh_stop);

  // ram port selection
  assign back_addr = POS_W'(last);
  assign ram_re    = cmd.shift_rd || cmd.rd_front || cmd.rd_back || cmd.rd_cur;
  always_comb begin
    if (cmd.shift_rd) begin
      ram_raddr = rd_ptr;
    end else if (cmd.rd_front) begin
      ram_raddr = '0;
    end else if (cmd.rd_back) begin
      ram_raddr = back_addr;
    end else begin
      ram_raddr = cpos;
    end
  end
  assign ram_we    = wr_pend || cmd.wr_val;
  assign ram_waddr = wr_pend ? wr_addr : val_addr;
  assign ram_wdata = wr_pend ? ram_rdata : val_q;

  cle_ram #(
    .WIDTH (cle_pkg::VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control registers: list state and pending shift write
  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      cpos    <= '0;
      cdef    <= 1'b0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= cmd.shift_rd;
      if (cmd.plan) begin
        len  <= n_len;
        cpos <= n_cpos;
        cdef <= n_cdef;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      act_q <= in_action;
      val_q <= in_value;
    end
    if (cmd.plan) begin
      st_q     <= p_st;
      ins_q    <= p_ins;
      rd_ptr   <= POS_W'(p_start);
      sh_stop  <= POS_W'(p_stop);
      val_addr <= POS_W'(p_pos);
    end
    if (cmd.shift_rd) begin
      rd_ptr  <= ins_q ? (rd_ptr - POS_W'(1)) : (rd_ptr + POS_W'(1));
      wr_addr <= ins_q ? (rd_ptr + POS_W'(1)) : (rd_ptr - POS_W'(1));
    end
    if (cmd.cap_front) begin
      front_q <= ram_rdata;
    end
    if (cmd.cap_back) begin
      back_q <= ram_rdata;
    end
    if (cmd.cap_cur) begin
      curv_q <= ram_rdata;
    end
    if (cmd.load_out) begin
      out_data <= OUT_TW'({
        cdef ? curv_q : '0,
        empty ? '0 : back_q,
        empty ? '0 : front_q,
        cdef ? cpos : '0,
        cdef,
        len,
        st_q
      });
    end
  end

endmodule

// File: hw/rtl/cursor_list_engine.sv
// top level of the cursor list engine: bounded list of 32-bit values with one cursor
//
//   channel  dir  payload                                              handshake
//   s_*      in   tuser: action[3:0]; tdata: value[31:0]              tvalid/tready
//   m_*      out  tdata: status, count, cursor_valid, cursor_at,      tvalid/tready
//                 front_value, back_value, cursor_value (low first)
//
// one item at a time: plan, shift of k cells when cells move (k up to CAPACITY-1), write of the
// value for an insert, reads of front, back and cursor; the single ram write port moves one cell a cycle
// a finished result waits in the output register while the next beat is taken in
// output stall holds the block in its last step until the result register frees
// rst is synchronous and active high; the element ram is not cleared
module cursor_list_engine #(
  parameter int CAPACITY = 64,
  localparam int CNT_W  = $clog2(CAPACITY + 1),
  localparam int POS_W  = $clog2(CAPACITY),
  localparam int OUT_W  = cle_pkg::ST_W + CNT_W + 1 + POS_W + 3 * cle_pkg::VAL_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [cle_pkg::VAL_W-1:0] s_tdata,  // value
  input  logic [cle_pkg::ACT_W-1:0] s_tuser,  // action
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status, count, cursor_valid, cursor_at, front_value, back_value, cursor_value, zero pad
  output logic [OUT_TW-1:0]         m_tdata
);

  cle_pkg::cmd_t  cmd;
  cle_pkg::stat_t stat;

  // controller
  cle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  cle_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_action (s_tuser),
    .in_value  (s_tdata),
    .out_data  (m_tdata)
  );

endmodule

// File: hw/rtl/cle_checker.sv
// port-level checker for the cursor list engine and its bind
module cle_checker #(
  parameter int CAPACITY = 64,
  localparam int CNT_W  = $clog2(CAPACITY + 1),
  localparam int POS_W  = $clog2(CAPACITY),
  localparam int OUT_W  = cle_pkg::ST_W + CNT_W + 1 + POS_W + 3 * cle_pkg::VAL_W,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8,
  localparam int CNT_LO = cle_pkg::ST_W,
  localparam int CV_B   = CNT_LO + CNT_W,
  localparam int CAT_LO = CV_B + 1,
  localparam int FR_LO  = CAT_LO + POS_W,
  localparam int BK_LO  = FR_LO + cle_pkg::VAL_W,
  localparam int CU_LO  = BK_LO + cle_pkg::VAL_W
) (
  input logic              clk,
  input logic              rst,
  input logic              s_tvalid,
  input logic              s_tready,
  input logic              m_tvalid,
  input logic              m_tready,
  input logic [OUT_TW-1:0] m_tdata
);

  logic [CNT_W-1:0]          count;
  logic                      cur_valid;
  logic [POS_W-1:0]          cur_at;
  logic [cle_pkg::VAL_W-1:0] front_v;
  logic [cle_pkg::VAL_W-1:0] back_v;
  logic [cle_pkg::VAL_W-1:0] cur_v;

  assign count     = m_tdata[CV_B-1:CNT_LO];
  assign cur_valid = m_tdata[CV_B];
  assign cur_at    = m_tdata[FR_LO-1:CAT_LO];
  assign front_v   = m_tdata[BK_LO-1:FR_LO];
  assign back_v    = m_tdata[CU_LO-1:BK_LO];
  assign cur_v     = m_tdata[CU_LO+cle_pkg::VAL_W-1:CU_LO];

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // one beat in flight: ready drops right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while one is in work");

  // a defined cursor lies inside the list
  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cur_valid |-> (CNT_W'(cur_at) < count))
    else $error("cursor outside the list");

  // an empty list reports no cursor and zero ends
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (count == '0) |-> !cur_valid && (front_v == '0) && (back_v == '0))
    else $error("empty list reports data");

  // an undefined cursor reports zero position and value
  a_nocur: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !cur_valid |-> (cur_at == '0) && (cur_v == '0))
    else $error("undefined cursor reports data");

endmodule

bind cursor_list_engine cle_checker #(
  .CAPACITY (CAPACITY)
) u_cle_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
